// ===== hdl/hpdg_pkg.sv =====
// ----------------------------------------------------------------------------
// hpdg_pkg
// Shared types and constants of the Householder poll direction generator.
// ----------------------------------------------------------------------------
package hpdg_pkg;

  // field widths fixed by the interface
  localparam int ROW_W   = 3;
  localparam int COL_W   = 4;
  localparam int VAL_W   = 18;
  localparam int VEC_W   = 16;
  localparam int EXP_W   = 6;
  localparam int SHIFT_W = 4;
  localparam int LIM_W   = 17;
  localparam int CFG_W   = 17;
  localparam int CIDX_W  = 1;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_SHIFT_OFFSET = 1'b0;
  localparam logic [CIDX_W-1:0] REG_CLAMP_LIMIT  = 1'b1;

  // reset values of the configuration registers
  localparam logic signed [EXP_W-1:0] SHIFT_OFFSET_RST = 6'sd0;
  localparam logic [LIM_W-1:0]        CLAMP_LIMIT_RST  = 17'd32768;

  // one in Q3.15
  localparam logic signed [VAL_W-1:0] ONE_Q15 = 18'sd32768;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [COL_W-1:0] col_t;

  // command from the controller to the datapath
  typedef struct packed {
    logic wr;      // store the input word
    logic fetch;   // read v_i and the row shift for a new row
    logic issue;   // read v_j and start one entry
    row_t row;
    row_t colb;    // column of B, before the negated half
    col_t col;     // column as presented on the output
    logic diag;
    logic neg;
    logic last;
  } dp_cmd_t;

endpackage

// ===== hdl/hpdg_ram.sv =====
// ----------------------------------------------------------------------------
// hpdg_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hpdg_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 4
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/hpdg_ctrl.sv =====
// ----------------------------------------------------------------------------
// hpdg_ctrl
// Controller: takes input words and sequences the direction set, one fetch
// per row followed by 2*DIMS entry reads, paced by the datapath pipeline.
// ----------------------------------------------------------------------------
module hpdg_ctrl #(
  parameter int DIMS = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  hpdg_pkg::row_t          in_element_index,
  input  logic                    adv,
  output hpdg_pkg::dp_cmd_t       cmd
);
  import hpdg_pkg::*;

  localparam row_t IDX_LIM  = ROW_W'(DIMS);
  localparam row_t LAST_IDX = ROW_W'(DIMS - 1);
  localparam col_t NEG_OFS  = COL_W'(DIMS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_COLS
  } state_t;

  state_t state_r, state_nxt;
  row_t   row_r, row_nxt;
  row_t   colb_r, colb_nxt;
  logic   neg_r, neg_nxt;
  logic   in_acc;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  // build the command for this cycle
  always_comb begin
    cmd       = '0;
    cmd.wr    = in_acc && (in_element_index < IDX_LIM);
    cmd.fetch = (state_r == ST_FETCH) && adv;
    cmd.issue = (state_r == ST_COLS) && adv;
    cmd.row   = row_r;
    cmd.colb  = colb_r;
    cmd.col   = neg_r ? (COL_W'(colb_r) + NEG_OFS) : COL_W'(colb_r);
    cmd.diag  = (colb_r == row_r);
    cmd.neg   = neg_r;
    cmd.last  = (row_r == LAST_IDX) && neg_r && (colb_r == LAST_IDX);
  end

  // advance the row and column counters
  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    colb_nxt  = colb_r;
    neg_nxt   = neg_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_element_index == LAST_IDX)) begin
          state_nxt = ST_FETCH;
          row_nxt   = '0;
        end
      end
      ST_FETCH: begin
        if (adv) begin
          state_nxt = ST_COLS;
          colb_nxt  = '0;
          neg_nxt   = 1'b0;
        end
      end
      ST_COLS: begin
        if (adv) begin
          if (colb_r == LAST_IDX) begin
            colb_nxt = '0;
            if (!neg_r) begin
              neg_nxt = 1'b1;
            end else if (row_r == LAST_IDX) begin
              state_nxt = ST_IDLE;
            end else begin
              row_nxt   = row_r + 1'b1;
              state_nxt = ST_FETCH;
            end
          end else begin
            colb_nxt = colb_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // hold state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      row_r   <= '0;
      colb_r  <= '0;
      neg_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      colb_r  <= colb_nxt;
      neg_r   <= neg_nxt;
    end
  end

  // at most one RAM operation per cycle
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.wr, cmd.fetch, cmd.issue}))
    else $error("hpdg_ctrl: RAM write and read commands overlap");

  // a final element starts a set and blocks further input
  a_set_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_element_index == LAST_IDX)) |=> (!in_ready && (row_r == '0)))
    else $error("hpdg_ctrl: set did not start after final element");

  // the last flag only rides on an issued entry of the final row
  a_last_issue: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue && cmd.last |=> (state_r == ST_IDLE))
    else $error("hpdg_ctrl: last entry issued but set not closed");

endmodule

// ===== hdl/hpdg_datapath.sv =====
// ----------------------------------------------------------------------------
// hpdg_datapath
// Datapath: vector store, configuration registers and the four-stage entry
// pipeline (RAM read, product, Householder entry with clamp, scale and round).
// ----------------------------------------------------------------------------
module hpdg_datapath #(
  parameter int DIMS = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  hpdg_pkg::dp_cmd_t                     cmd,
  output logic                                  adv,
  input  hpdg_pkg::row_t                        in_element_index,
  input  logic signed [hpdg_pkg::VEC_W-1:0]     in_rand_value,
  input  logic signed [hpdg_pkg::EXP_W-1:0]     in_frame_exp,
  input  logic signed [hpdg_pkg::EXP_W-1:0]     in_mesh_exp,
  input  logic                                  cfg_we,
  input  logic [hpdg_pkg::CIDX_W-1:0]           cfg_index,
  input  logic [hpdg_pkg::CFG_W-1:0]            cfg_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output hpdg_pkg::row_t                        out_row_index,
  output hpdg_pkg::col_t                        out_column_index,
  output logic signed [hpdg_pkg::VAL_W-1:0]     out_direction_value,
  output logic                                  out_last_entry
);
  import hpdg_pkg::*;

  localparam int AW    = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int WORD_W = SHIFT_W + VEC_W;
  localparam int SUM_W  = EXP_W + 2;

  // configuration registers
  logic signed [EXP_W-1:0] shift_offset_r;
  logic [LIM_W-1:0]        clamp_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_offset_r <= SHIFT_OFFSET_RST;
      clamp_limit_r  <= CLAMP_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHIFT_OFFSET: shift_offset_r <= $signed(cfg_data[EXP_W-1:0]);
        REG_CLAMP_LIMIT:  clamp_limit_r  <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // row shift: frame - mesh + offset, saturated to 0..15
  logic signed [SUM_W-1:0] shift_sum;
  logic [SHIFT_W-1:0]      shift_sat;

  assign shift_sum = SUM_W'(in_frame_exp) - SUM_W'(in_mesh_exp) + SUM_W'(shift_offset_r);

  always_comb begin
    priority if (shift_sum < 0) begin
      shift_sat = '0;
    end else if (shift_sum > SUM_W'(2**SHIFT_W - 1)) begin
      shift_sat = '1;
    end else begin
      shift_sat = shift_sum[SHIFT_W-1:0];
    end
  end

  // vector and shift store
  logic [WORD_W-1:0] rd_word;
  logic [AW-1:0]     rd_addr;

  assign rd_addr = cmd.fetch ? cmd.row[AW-1:0] : cmd.colb[AW-1:0];

  hpdg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DIMS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (in_element_index[AW-1:0]),
    .wdata ({shift_sat, in_rand_value}),
    .re    (cmd.fetch || cmd.issue),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  // pipeline advances whenever the output register is free or drains
  logic out_valid_r;
  assign adv = !out_valid_r || out_ready;

  // stage A: tags alongside the RAM read
  logic a_vld_r, a_fetch_r;
  row_t a_row_r;
  col_t a_col_r;
  logic a_diag_r, a_neg_r, a_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      a_fetch_r <= 1'b0;
    end else if (adv) begin
      a_vld_r   <= cmd.issue;
      a_fetch_r <= cmd.fetch;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_row_r  <= cmd.row;
      a_col_r  <= cmd.col;
      a_diag_r <= cmd.diag;
      a_neg_r  <= cmd.neg;
      a_last_r <= cmd.last;
    end
  end

  // stage B: latch v_i on a fetch, form v_i * v_j
  logic signed [VEC_W-1:0]   vi_r;
  logic [SHIFT_W-1:0]        sh_r;
  logic                      b_vld_r;
  logic signed [2*VEC_W-1:0] b_prod_r;
  logic [SHIFT_W-1:0]        b_shift_r;
  row_t                      b_row_r;
  col_t                      b_col_r;
  logic                      b_diag_r, b_neg_r, b_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (a_fetch_r) begin
        vi_r <= $signed(rd_word[VEC_W-1:0]);
        sh_r <= rd_word[WORD_W-1:VEC_W];
      end
      b_prod_r  <= vi_r * $signed(rd_word[VEC_W-1:0]);
      b_shift_r <= sh_r;
      b_row_r   <= a_row_r;
      b_col_r   <= a_col_r;
      b_diag_r  <= a_diag_r;
      b_neg_r   <= a_neg_r;
      b_last_r  <= a_last_r;
    end
  end

  // stage C: h = [diag] - 2p rounded, clamped, negated for the mirror half
  logic [2*VEC_W-1:0]      p_mag;
  logic [2*VEC_W-1:0]      p_rnd;
  logic [LIM_W-1:0]        p_q;
  logic signed [VAL_W-1:0] p_s;
  logic signed [VAL_W-1:0] h_raw, h_lim, h_clp;

  assign p_mag = b_prod_r[2*VEC_W-1] ? (-b_prod_r) : b_prod_r;
  assign p_rnd = p_mag + (2*VEC_W)'(1 << 13);
  assign p_q   = p_rnd[LIM_W+13:14];
  // restore the sign of the rounded product
  assign p_s   = b_prod_r[2*VEC_W-1] ? -$signed({1'b0, p_q}) : $signed({1'b0, p_q});
  assign h_raw = (b_diag_r ? ONE_Q15 : '0) - p_s;
  assign h_lim = $signed({1'b0, clamp_limit_r});

  always_comb begin
    priority if (h_raw > h_lim) begin
      h_clp = h_lim;
    end else if (h_raw < -h_lim) begin
      h_clp = -h_lim;
    end else begin
      h_clp = h_raw;
    end
  end

  logic                    c_vld_r;
  logic signed [VAL_W-1:0] c_h_r;
  logic [SHIFT_W-1:0]      c_shift_r;
  row_t                    c_row_r;
  col_t                    c_col_r;
  logic                    c_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_h_r     <= b_neg_r ? -h_clp : h_clp;
      c_shift_r <= b_shift_r;
      c_row_r   <= b_row_r;
      c_col_r   <= b_col_r;
      c_last_r  <= b_last_r;
    end
  end

  // output stage: scale by 2^shift, drop 15 fraction bits rounding away
  logic [LIM_W-1:0]    h_mag;
  logic [31:0]         h_scl;
  logic [31:0]         h_rnd;
  logic [LIM_W-1:0]    q_mag;
  logic signed [VAL_W-1:0] q_val;

  assign h_mag = c_h_r[VAL_W-1] ? LIM_W'(-c_h_r) : c_h_r[LIM_W-1:0];
  assign h_scl = 32'(h_mag) << c_shift_r;
  assign h_rnd = h_scl + 32'(1 << 14);
  assign q_mag = h_rnd[LIM_W+14:15];
  assign q_val = c_h_r[VAL_W-1] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

  logic signed [VAL_W-1:0] out_val_r;
  row_t                    out_row_r;
  col_t                    out_col_r;
  logic                    out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_val_r  <= q_val;
      out_row_r  <= c_row_r;
      out_col_r  <= c_col_r;
      out_last_r <= c_last_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_row_index       = out_row_r;
  assign out_column_index    = out_col_r;
  assign out_direction_value = out_val_r;
  assign out_last_entry      = out_last_r;

  // a fetch slot never carries an entry down the pipe
  a_fetch_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    !(a_vld_r && a_fetch_r))
    else $error("hpdg_datapath: fetch and entry share stage A");

  // the last word sits in the final row and column
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |->
      (out_row_r == ROW_W'(DIMS - 1)) && (out_col_r == COL_W'(2*DIMS - 1)))
    else $error("hpdg_datapath: last word at wrong position");

  // the magnitude has only LIM_W bits, so negative full scale never appears
  a_val_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_val_r != $signed({1'b1, {(VAL_W-1){1'b0}}})))
    else $error("hpdg_datapath: word reached negative full scale");

endmodule

// ===== hdl/householder_poll_direction_gen_unit.sv =====
// ----------------------------------------------------------------------------
// householder_poll_direction_gen_unit
// Top level: collects a Q1.15 unit vector and emits the [B | -B] poll
// direction matrix derived from its Householder reflection.
// ----------------------------------------------------------------------------
// Each input word loads one element v[k] with its row shift (frame - mesh +
// shift_offset, saturated to 0..15); words with an index of DIMS or more are
// dropped. A non-final element is accepted whenever the unit is idle. The
// element with index DIMS-1 starts a set of 2*DIMS*DIMS output words in
// row-major order, and the input stays blocked while the set is sequenced:
// each row first fetches v_i and its shift from the single read port of the
// vector store, then reads the 2*DIMS entries of the row, pausing while the
// output stalls. Output words leave at up to one per cycle while out_ready is
// high; the next set may load while the tail of the previous one drains.
// Configuration writes take effect at once and belong to idle periods only.
module householder_poll_direction_gen_unit #(
  parameter int DIMS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [hpdg_pkg::ROW_W-1:0]           in_element_index,
  input  logic signed [hpdg_pkg::VEC_W-1:0]    in_rand_value,
  input  logic signed [hpdg_pkg::EXP_W-1:0]    in_frame_exp,
  input  logic signed [hpdg_pkg::EXP_W-1:0]    in_mesh_exp,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [hpdg_pkg::ROW_W-1:0]           out_row_index,
  output logic [hpdg_pkg::COL_W-1:0]           out_column_index,
  output logic signed [hpdg_pkg::VAL_W-1:0]    out_direction_value,
  output logic                                 out_last_entry,
  input  logic                                 cfg_we,
  input  logic [hpdg_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [hpdg_pkg::CFG_W-1:0]           cfg_data
);
  import hpdg_pkg::*;

  dp_cmd_t cmd;
  logic    adv;

  // sequence loads and the direction set
  hpdg_ctrl #(
    .DIMS (DIMS)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_element_index (in_element_index),
    .adv              (adv),
    .cmd              (cmd)
  );

  // store, compute and present the entries
  hpdg_datapath #(
    .DIMS (DIMS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .adv                 (adv),
    .in_element_index    (in_element_index),
    .in_rand_value       (in_rand_value),
    .in_frame_exp        (in_frame_exp),
    .in_mesh_exp         (in_mesh_exp),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_row_index       (out_row_index),
    .out_column_index    (out_column_index),
    .out_direction_value (out_direction_value),
    .out_last_entry      (out_last_entry)
  );

endmodule

// ===== bench/hpdg_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hpdg_checker
// Watches the input, output and register ports of the poll direction
// generator. It keeps its own copy of the vector and row shift stores, builds
// the [B | -B] direction set for every word with the final index, and compares
// each accepted output word field by field with the oldest predicted word.
// ----------------------------------------------------------------------------
module hpdg_checker #(
  parameter int DIMS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic [hpdg_pkg::ROW_W-1:0]           in_element_index,
  input  logic signed [hpdg_pkg::VEC_W-1:0]    in_rand_value,
  input  logic signed [hpdg_pkg::EXP_W-1:0]    in_frame_exp,
  input  logic signed [hpdg_pkg::EXP_W-1:0]    in_mesh_exp,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic [hpdg_pkg::ROW_W-1:0]           out_row_index,
  input  logic [hpdg_pkg::COL_W-1:0]           out_column_index,
  input  logic signed [hpdg_pkg::VAL_W-1:0]    out_direction_value,
  input  logic                                 out_last_entry,
  input  logic                                 cfg_we,
  input  logic [hpdg_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [hpdg_pkg::CFG_W-1:0]           cfg_data,
  output int                                   fail_count,
  output int                                   pending_words
);
  import hpdg_pkg::*;

  localparam longint VAL_MAX = (longint'(1) <<< (VAL_W - 1)) - 1;
  localparam longint VAL_MIN = -(longint'(1) <<< (VAL_W - 1));
  localparam int     SHIFT_MAX = (1 << SHIFT_W) - 1;

  typedef struct {
    row_t                    row;
    col_t                    col;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } dir_word_t;

  dir_word_t               direction_q[$];
  logic signed [VEC_W-1:0] vec_mem   [DIMS];
  logic [SHIFT_W-1:0]      row_shift [DIMS];
  logic signed [EXP_W-1:0] offset_reg;
  logic [LIM_W-1:0]        clamp_reg;

  initial begin
    fail_count    = 0;
    pending_words = 0;
  end

  task automatic report_error(input string msg);
    fail_count++;
    $display("%0t ns: %s", $time, msg);
  endtask

  // divide by 2^k, round to nearest with ties away from zero
  function automatic longint round_away(input longint x, input int k);
    longint mag;
    mag = (x < 0) ? -x : x;
    mag = (mag + (longint'(1) <<< (k - 1))) >>> k;
    return (x < 0) ? -mag : mag;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_val(input longint x);
    if (x > VAL_MAX) return VAL_W'(VAL_MAX);
    if (x < VAL_MIN) return VAL_W'(VAL_MIN);
    return VAL_W'(x);
  endfunction

  // one entry of B: clamped Householder entry, scaled by the row shift
  function automatic logic signed [VAL_W-1:0] direction_entry(input int i, input int j);
    longint prod;
    longint h;
    prod = longint'(vec_mem[i]) * longint'(vec_mem[j]);
    h = -round_away(prod, 14);
    if (i == j) h += longint'(ONE_Q15);
    if (h > longint'(clamp_reg)) h = longint'(clamp_reg);
    else if (h < -longint'(clamp_reg)) h = -longint'(clamp_reg);
    h = h <<< row_shift[i];
    return sat_val(round_away(h, 15));
  endfunction

  // queue the whole [B | -B] set in row-major order
  task automatic predict_direction_set();
    dir_word_t w;
    for (int i = 0; i < DIMS; i++) begin
      for (int j = 0; j < 2 * DIMS; j++) begin
        w.row   = ROW_W'(i);
        w.col   = COL_W'(j);
        w.value = direction_entry(i, (j < DIMS) ? j : j - DIMS);
        if (j >= DIMS) w.value = sat_val(-longint'(w.value));
        w.last  = (i == DIMS - 1) && (j == 2 * DIMS - 1);
        direction_q.push_back(w);
      end
    end
  endtask

  always @(posedge clk) begin
    int        s;
    dir_word_t want;
    if (!rst_n) begin
      offset_reg = SHIFT_OFFSET_RST;
      clamp_reg  = CLAMP_LIMIT_RST;
      direction_q.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_SHIFT_OFFSET: offset_reg = cfg_data[EXP_W-1:0];
          REG_CLAMP_LIMIT:  clamp_reg  = cfg_data[LIM_W-1:0];
          default: ;
        endcase
      end

      // load an element; drop words whose index is out of range
      if (in_valid && in_ready && in_element_index < DIMS) begin
        s = int'(in_frame_exp) - int'(in_mesh_exp) + int'(offset_reg);
        if (s < 0) s = 0;
        if (s > SHIFT_MAX) s = SHIFT_MAX;
        vec_mem[in_element_index]   = in_rand_value;
        row_shift[in_element_index] = SHIFT_W'(s);
        if (in_element_index == DIMS - 1) predict_direction_set();
      end

      // compare each output word with the oldest prediction
      if (out_valid && out_ready) begin
        if (direction_q.size() == 0) begin
          report_error($sformatf("unexpected word row %0d col %0d value %0d",
                                 out_row_index, out_column_index, out_direction_value));
        end else begin
          want = direction_q.pop_front();
          if (out_row_index !== want.row)
            report_error($sformatf("row_index %0d, expected %0d", out_row_index, want.row));
          if (out_column_index !== want.col)
            report_error($sformatf("column_index %0d, expected %0d (row %0d)",
                                   out_column_index, want.col, want.row));
          if (out_direction_value !== want.value)
            report_error($sformatf("direction_value %0d, expected %0d (row %0d col %0d)",
                                   out_direction_value, want.value, want.row, want.col));
          if (out_last_entry !== want.last)
            report_error($sformatf("last_entry %0b, expected %0b (row %0d col %0d)",
                                   out_last_entry, want.last, want.row, want.col));
        end
      end
    end
    pending_words = direction_q.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the Householder poll direction generator. Drives
// directed corner words, then random vector loads under several register
// settings and idle/stall mixes, including a long output hold-off that backs
// the block up. Prediction and comparison live in hpdg_checker.
// ----------------------------------------------------------------------------
module tb;
  import hpdg_pkg::*;

  localparam int DIMS           = 4;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 16;
  localparam int PHASE_WORDS    = 25;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [ROW_W-1:0]        in_element_index;
  logic signed [VEC_W-1:0] in_rand_value;
  logic signed [EXP_W-1:0] in_frame_exp;
  logic signed [EXP_W-1:0] in_mesh_exp;
  logic                    out_valid;
  logic                    out_ready;
  logic [ROW_W-1:0]        out_row_index;
  logic [COL_W-1:0]        out_column_index;
  logic signed [VAL_W-1:0] out_direction_value;
  logic                    out_last_entry;
  logic                    cfg_we;
  logic [CIDX_W-1:0]       cfg_index;
  logic [CFG_W-1:0]        cfg_data;
  int                      err_count;
  int                      pending_words;

  // idle mix, changed only at a rising edge while the block is quiet
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_req  = 0;

  householder_poll_direction_gen_unit #(.DIMS(DIMS)) dut (.*);

  hpdg_checker #(.DIMS(DIMS)) chk (
    .*,
    .fail_count    (err_count),
    .pending_words (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // output side: random stalls, plus a long hold-off on request
  initial begin : receiver
    int hold_left;
    int hold_done;
    hold_left = 0;
    hold_done = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req != hold_done) begin
        hold_done = hold_req;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // end the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // offer one word and hold it until accepted
  task automatic push_element(input int idx, input int val, input int fe, input int me);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_element_index <= ROW_W'(idx);
    in_rand_value    <= VEC_W'(val);
    in_frame_exp     <= EXP_W'(fe);
    in_mesh_exp      <= EXP_W'(me);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic int pick_vec();
    case ($urandom_range(7))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  // random exponents, half of them near each other so the shift is not pinned
  task automatic push_random(input int idx);
    int fe;
    int me;
    fe = int'($urandom_range(63)) - 32;
    if ($urandom_range(1)) me = int'($urandom_range(63)) - 32;
    else me = fe - int'($urandom_range(17));
    push_element(idx, pick_vec(), fe, me);
  endtask

  // drop valid, wait for every set to drain, end on a rising edge
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(input logic signed [EXP_W-1:0] off, input logic [LIM_W-1:0] lim);
    write_reg(REG_SHIFT_OFFSET, CFG_W'(off));
    write_reg(REG_CLAMP_LIMIT, CFG_W'(lim));
  endtask

  // mostly full vector loads; some stray words and cut-short loads
  task automatic run_random(input int target);
    int loaded;
    int kind;
    int n;
    int k;
    loaded = 0;
    while (loaded < target) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        for (k = 0; k < DIMS; k++) push_random(k);
        loaded += DIMS;
      end else if (kind < 85) begin
        k = $urandom_range(7);
        push_random(k);
        if (k < DIMS) loaded++;
      end else begin
        n = $urandom_range(DIMS - 2);
        repeat (n) push_random($urandom_range(DIMS - 2));
        push_random(DIMS - 1);
        loaded += n + 1;
      end
    end
  endtask

  initial begin : stimulus
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_element_index = '0;
    in_rand_value    = '0;
    in_frame_exp     = '0;
    in_mesh_exp      = '0;
    cfg_we           = 1'b0;
    cfg_index        = REG_SHIFT_OFFSET;
    cfg_data         = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, saturated shifts, ignored indexes, reloads
    push_element(0, 32767, 31, -32);
    push_element(1, -32768, -32, 31);
    push_element(2, 0, 0, 0);
    push_element(5, -32768, -1, -1);
    push_element(3, -1, 5, 2);
    push_element(7, 32767, 0, 0);
    push_element(4, 1234, 3, 3);
    push_element(6, -4321, 31, -32);
    push_element(2, 23170, 3, 1);
    push_element(3, -23170, -3, 4);
    push_element(3, -23170, -3, 4);
    push_element(0, -32768, 10, 10);
    push_element(1, 16384, 15, 0);
    push_element(3, 32767, 31, 31);

    // phases of register settings and idle mixes
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          idle_pct = 0;  stall_pct = 0;
          set_config(-6'sd16, 17'd0);
        end
        1: begin
          idle_pct = 79; stall_pct = 0;
          set_config(6'sd16, 17'd131071);
        end
        2: begin
          idle_pct = 0;  stall_pct = 79;
          set_config(-6'sd1, LIM_W'($urandom_range(131071)));
        end
        default: begin
          idle_pct = 37; stall_pct = 37;
          set_config(6'sd15, CLAMP_LIMIT_RST);
        end
      endcase
      run_random(PHASE_WORDS);
    end

    // back-pressure: hold the output while the sender keeps offering
    wait_drained();
    idle_pct  = 0;
    stall_pct = 0;
    set_config(EXP_W'(int'($urandom_range(32)) - 16), LIM_W'($urandom_range(70000)));
    @(posedge clk);
    hold_req++;
    for (int s = 0; s < 3; s++) begin
      for (int k = 0; k < DIMS; k++) push_random(k);
    end

    wait_drained();
    if (err_count == 0 && pending_words == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/hpdg_pkg.sv
hdl/hpdg_ram.sv
hdl/hpdg_ctrl.sv
hdl/hpdg_datapath.sv
hdl/householder_poll_direction_gen_unit.sv
bench/hpdg_checker.sv
bench/tb.sv
